>>> rtl/core/i2cmra_pkg.sv
// Shared types and constants for the I2C master register access unit.
`default_nettype none
package i2cmra_pkg;
  localparam int unsigned MaxBytes     = 16;
  localparam int unsigned AckPollLimit = 50;
  localparam int unsigned BufAw        = $clog2(MaxBytes);
  localparam int unsigned CntW         = $clog2(MaxBytes + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // one classified beat passed from the front end to the sequencer
  typedef struct packed {
    op_e         op;
    logic [3:0]  buffer_index;
    logic [7:0]  write_byte;
    logic [6:0]  slave_address;
    logic [15:0] register_address;
    logic        is_read;
    logic [4:0]  byte_count;
    logic        sda_sampled;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       address_nack;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
  } res_t;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(res_t);
endpackage
`default_nettype wire

>>> rtl/core/i2cmra_fifo.sv
// Two-entry queue between front end and sequencer (also used for results).
`default_nettype none
module i2cmra_fifo (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [i2cmra_pkg::CmdW-1:0]  in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [i2cmra_pkg::CmdW-1:0]  out_data_o
);
  import i2cmra_pkg::*;

  logic [CmdW-1:0] mem_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/i2cmra_front.sv
// Front end: unpacks input beats into commands for the sequencer.
`default_nettype none
module i2cmra_front (
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire  [47:0]                 s_axis_tdata,
  output logic                        cmd_valid_o,
  input  wire                         cmd_ready_i,
  output i2cmra_pkg::cmd_t            cmd_o
);
  import i2cmra_pkg::*;

  cmd_t       cmd;

  assign cmd.op               = op_e'(s_axis_tdata[1:0]);
  assign cmd.buffer_index     = s_axis_tdata[5:2];
  assign cmd.write_byte       = s_axis_tdata[13:6];
  assign cmd.slave_address    = s_axis_tdata[20:14];
  assign cmd.register_address = s_axis_tdata[36:21];
  assign cmd.is_read          = s_axis_tdata[37];
  assign cmd.byte_count       = s_axis_tdata[42:38];
  assign cmd.sda_sampled      = s_axis_tdata[43];

  assign s_axis_tready = cmd_ready_i;
  assign cmd_valid_o   = s_axis_tvalid;
  assign cmd_o         = cmd;
endmodule
`default_nettype wire

>>> rtl/core/i2cmra_seq.sv
// Back end: bus sequencer stepped by tick commands, one result per command.
`default_nettype none
module i2cmra_seq (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          fast_mode_i,
  input  wire                          wide_reg_i,
  input  wire                          cmd_valid_i,
  output logic                         cmd_ready_o,
  input  wire  [i2cmra_pkg::CmdW-1:0]  cmd_i,
  output logic                         res_valid_o,
  input  wire                          res_ready_i,
  output i2cmra_pkg::res_t             res_o
);
  import i2cmra_pkg::*;

  typedef enum logic [4:0] {
    P_IDLE, P_START_A, P_START_B, P_START_C, P_TX_LOW, P_TX_SET, P_TX_HIGH,
    P_ACK_LOW, P_ACK_REL, P_ACK_HIGH, P_ACK_POLL, P_ACK_END, P_RX_PRE,
    P_RX_LOW, P_RX_HIGH, P_MACK_LOW, P_MACK_SET, P_MACK_HIGH, P_MACK_END,
    P_STOP_A, P_STOP_B, P_STOP_C, P_STOP_D
  } phase_e;

  typedef enum logic [2:0] {
    R_ADDR_W, R_REG_HI, R_REG_LO, R_ADDR_R, R_DATA_W, R_DATA_R
  } role_e;

  cmd_t        cmd;
  phase_e      ph_q, ph_d;
  role_e       role_q, role_d;
  logic [1:0]  dly_q, dly_d;
  logic [3:0]  bit_q, bit_d;
  logic [CntW-1:0] done_q, done_d, cnt_q, cnt_d;
  logic [7:0]  sh_q, sh_d;
  logic [5:0]  polls_q, polls_d;
  logic [6:0]  slv_q, slv_d;
  logic [15:0] reg_q, reg_d;
  logic        dir_q, dir_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic        ev_done, ev_nack, ev_valid, ev_last;
  logic [7:0]  ev_data;
  logic        go, is_last;
  logic [CntW-1:0] done_inc;
  logic [7:0]  buf_q [MaxBytes];

  assign cmd         = cmd_t'(cmd_i);
  assign cmd_ready_o = res_ready_i;
  assign res_valid_o = cmd_valid_i;
  assign go          = cmd_valid_i && res_ready_i;
  assign is_last     = ({1'b0, done_q} + 1'b1) >= {1'b0, cnt_q};
  assign done_inc    = done_q + 1'b1;

  // write buffer; loads take effect in beat order with the ticks
  always_ff @(posedge clk_i) begin
    if (go && cmd.op == OP_LOAD && {1'b0, cmd.buffer_index} < 5'(MaxBytes))
      buf_q[cmd.buffer_index[BufAw-1:0]] <= cmd.write_byte;
  end

  // next-state logic; pin updates follow entry into each phase
  always_comb begin
    phase_e nx;
    logic   ent;
    logic   snd;
    role_e  sr;
    logic [7:0] sb;
    ph_d = ph_q; role_d = role_q; dly_d = dly_q; bit_d = bit_q;
    done_d = done_q; cnt_d = cnt_q; sh_d = sh_q; polls_d = polls_q;
    slv_d = slv_q; reg_d = reg_q; dir_d = dir_q; scl_d = scl_q; sda_d = sda_q;
    ev_done = 1'b0; ev_nack = 1'b0; ev_valid = 1'b0; ev_last = 1'b0;
    ev_data = 8'h00;
    nx = ph_q; ent = 1'b0; snd = 1'b0; sr = role_q; sb = 8'h00;
    if (cmd.op == OP_START && ph_q == P_IDLE) begin
      slv_d = cmd.slave_address;
      reg_d = cmd.register_address;
      dir_d = cmd.is_read;
      cnt_d = (cmd.byte_count > 5'(MaxBytes)) ? CntW'(MaxBytes)
                                               : CntW'(cmd.byte_count);
      done_d = '0; polls_d = '0; role_d = R_ADDR_W;
      nx = P_START_A; ent = 1'b1;
    end else if (cmd.op == OP_TICK && ph_q != P_IDLE) begin
      if (ph_q == P_ACK_POLL) begin
        if (!cmd.sda_sampled) begin
          nx = P_ACK_END; ent = 1'b1;
        end else begin
          polls_d = polls_q + 1'b1;
          if (polls_d > 6'(AckPollLimit)) begin
            nx = (role_q == R_ADDR_W) ? P_STOP_A : P_ACK_END; ent = 1'b1;
          end
        end
      end else if (!fast_mode_i && dly_q != 2'd3) begin
        dly_d = dly_q + 1'b1;
      end else begin
        ent = 1'b1;
        case (ph_q)
          P_START_A:  nx = P_START_B;
          P_START_B:  nx = P_START_C;
          P_START_C:  begin snd = 1'b1; sr = role_q; end
          P_TX_LOW:   nx = P_TX_SET;
          P_TX_SET:   nx = P_TX_HIGH;
          P_TX_HIGH: begin
            sh_d = {sh_q[6:0], 1'b0};
            bit_d = bit_q + 1'b1;
            nx = (bit_d >= 4'd8) ? P_ACK_LOW : P_TX_LOW;
          end
          P_ACK_LOW:  nx = P_ACK_REL;
          P_ACK_REL:  nx = P_ACK_HIGH;
          P_ACK_HIGH: begin polls_d = '0; nx = P_ACK_POLL; end
          P_ACK_END: begin
            case (role_q)
              R_ADDR_W: begin snd = 1'b1; sr = wide_reg_i ? R_REG_HI : R_REG_LO; end
              R_REG_HI: begin snd = 1'b1; sr = R_REG_LO; end
              R_REG_LO: begin
                if (dir_q) begin role_d = R_ADDR_R; nx = P_START_A; end
                else if (cnt_q != '0) begin snd = 1'b1; sr = R_DATA_W; end
                else nx = P_STOP_A;
              end
              R_ADDR_R: begin
                if (cnt_q != '0) begin role_d = R_DATA_R; nx = P_RX_PRE; end
                else nx = P_STOP_A;
              end
              default: begin
                done_d = done_inc;
                if (done_inc < cnt_q) begin snd = 1'b1; sr = R_DATA_W; end
                else nx = P_STOP_A;
              end
            endcase
          end
          P_RX_PRE: begin bit_d = '0; sh_d = '0; nx = P_RX_LOW; end
          P_RX_LOW:   nx = P_RX_HIGH;
          P_RX_HIGH: begin
            sh_d = {sh_q[6:0], cmd.sda_sampled};
            bit_d = bit_q + 1'b1;
            if (bit_d >= 4'd8) begin
              ev_valid = 1'b1; ev_data = sh_d; ev_last = is_last;
              nx = P_MACK_LOW;
            end else nx = P_RX_LOW;
          end
          P_MACK_LOW:  nx = P_MACK_SET;
          P_MACK_SET:  nx = P_MACK_HIGH;
          P_MACK_HIGH: nx = P_MACK_END;
          P_MACK_END: begin
            done_d = done_inc;
            nx = (done_inc < cnt_q) ? P_RX_PRE : P_STOP_A;
          end
          P_STOP_A: nx = P_STOP_B;
          P_STOP_B: nx = P_STOP_C;
          P_STOP_C: nx = P_STOP_D;
          P_STOP_D: begin
            ev_done = 1'b1; ev_nack = (role_q == R_ADDR_W);
            nx = P_IDLE;
          end
          default: nx = P_IDLE;
        endcase
      end
    end
    // byte launch; data bytes come from the slot of the updated byte count
    if (snd) begin
      case (sr)
        R_ADDR_W: sb = {slv_q, 1'b0};
        R_ADDR_R: sb = {slv_q, 1'b1};
        R_REG_HI: sb = reg_q[15:8];
        R_REG_LO: sb = reg_q[7:0];
        default:  sb = buf_q[done_d[BufAw-1:0]];
      endcase
      role_d = sr; sh_d = sb; bit_d = '0; nx = P_TX_LOW;
    end
    if (ent) begin
      ph_d = nx; dly_d = '0;
      case (nx)
        P_START_A: begin scl_d = 1'b1; sda_d = 1'b1; end
        P_START_B, P_START_C, P_STOP_B: sda_d = 1'b0;
        P_TX_SET:  sda_d = sh_d[7];
        P_MACK_SET: sda_d = is_last;
        P_ACK_REL, P_RX_PRE, P_STOP_D: sda_d = 1'b1;
        P_TX_HIGH, P_ACK_HIGH, P_RX_HIGH, P_MACK_HIGH, P_STOP_C: scl_d = 1'b1;
        P_TX_LOW, P_ACK_LOW, P_ACK_END, P_RX_LOW, P_MACK_LOW, P_MACK_END,
        P_STOP_A: scl_d = 1'b0;
        default: ;
      endcase
    end
  end

  // result for this beat
  always_comb begin
    res_o.scl_level    = scl_d;
    res_o.sda_level    = sda_d;
    res_o.busy_res     = (ph_d != P_IDLE);
    res_o.done_res     = ev_done;
    res_o.address_nack = ev_nack;
    res_o.read_data    = ev_data;
    res_o.read_valid   = ev_valid;
    res_o.read_last    = ev_last;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= P_IDLE; role_q <= R_ADDR_W; dly_q <= '0; bit_q <= '0;
      done_q <= '0; cnt_q <= '0; sh_q <= '0; polls_q <= '0; slv_q <= '0;
      reg_q <= '0; dir_q <= 1'b0; scl_q <= 1'b1; sda_q <= 1'b1;
    end else if (go) begin
      ph_q <= ph_d; role_q <= role_d; dly_q <= dly_d; bit_q <= bit_d;
      done_q <= done_d; cnt_q <= cnt_d; sh_q <= sh_d; polls_q <= polls_d;
      slv_q <= slv_d; reg_q <= reg_d; dir_q <= dir_d; scl_q <= scl_d;
      sda_q <= sda_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/i2c_master_register_access_unit.sv
// Top level: I2C master register access unit.
// Flow: a beat is registered in the command queue, and the sequencer's result for
// it is registered in the output queue once that queue has room.
// Throughput: one beat per cycle unless a full queue holds the flow.
// Reset: asynchronous active low; idle, lines released, fast mode on.
`default_nettype none
module i2c_master_register_access_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0] buffer_index[5:2] write_byte[13:6] slave_address[20:14]
  // register_address[36:21] is_read[37] byte_count[42:38] sda_sampled[43]
  input  wire  [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // scl_level[0] sda_level[1] busy_res[2] done_res[3] address_nack[4]
  // read_data[12:5] read_valid[13] read_last[14]
  output logic [15:0] m_axis_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cmra_pkg::*;

  localparam logic [2:0] AddrFast = 3'd0;
  localparam logic [2:0] AddrWide = 3'd4;

  logic fast_q, wide_q;
  logic fv, fr, qv, qr, rv, rr;
  cmd_t fcmd;
  logic [CmdW-1:0] qcmd, rdw, rqo;
  res_t res;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= 1'b1;
      wide_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrFast) fast_q <= pwdata[0];
      if (paddr == AddrWide) wide_q <= pwdata[0];
    end
  end
  always_comb begin
    case (paddr)
      AddrFast: prdata = {31'd0, fast_q};
      AddrWide: prdata = {31'd0, wide_q};
      default:  prdata = 32'd0;
    endcase
  end

  i2cmra_front u_front (
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cmd_valid_o(fv), .cmd_ready_i(fr), .cmd_o(fcmd)
  );

  i2cmra_fifo u_cmdq (
    .clk_i, .rst_ni, .in_valid_i(fv), .in_ready_o(fr), .in_data_i(fcmd),
    .out_valid_o(qv), .out_ready_i(qr), .out_data_o(qcmd)
  );

  i2cmra_seq u_seq (
    .clk_i, .rst_ni, .fast_mode_i(fast_q), .wide_reg_i(wide_q),
    .cmd_valid_i(qv), .cmd_ready_o(qr), .cmd_i(qcmd),
    .res_valid_o(rv), .res_ready_i(rr), .res_o(res)
  );

  assign rdw = CmdW'(res);

  i2cmra_fifo u_resq (
    .clk_i, .rst_ni, .in_valid_i(rv), .in_ready_o(rr), .in_data_i(rdw),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(rqo)
  );

  // res_t packs read_last at bit 0; reorder onto the stream fields
  always_comb begin
    res_t r;
    r = res_t'(rqo[ResW-1:0]);
    m_axis_tdata = {1'b0, r.read_last, r.read_valid, r.read_data, r.address_nack,
                    r.done_res, r.busy_res, r.sda_level, r.scl_level};
  end
endmodule
`default_nettype wire
